// ===== rtl/lfucl_pkg.sv =====
// ----------------------------------------------------------------------------
// lfucl_pkg: shared types for the LFU cache lookup and replace unit
// Search token handed along the cell chain, and the write command that the
// control logic broadcasts back to the cells once the search is complete.
// ----------------------------------------------------------------------------
package lfucl_pkg;

  localparam int ENTRIES_DEFAULT = 16;
  localparam int ENTRIES_MAX     = 64;
  localparam int SLOT_IDX_W      = $clog2(ENTRIES_MAX);
  localparam int FILL_W          = $clog2(ENTRIES_MAX + 1);
  localparam int KEY_W           = 32;
  localparam int DATA_W          = 32;
  localparam int CAP_W           = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic [31:0] SAT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_TOUCH,
    WR_INSTALL
  } wr_op_t;

  typedef struct packed {
    logic                  active;
    logic [KEY_W-1:0]      key;
    logic [FILL_W-1:0]     fill;
    logic                  match_found;
    logic [SLOT_IDX_W-1:0] match_idx;
    logic [DATA_W-1:0]     match_data;
    logic                  free_found;
    logic [SLOT_IDX_W-1:0] free_idx;
    logic                  victim_found;
    logic [SLOT_IDX_W-1:0] victim_idx;
    logic [31:0]           victim_count;
    logic [31:0]           victim_stamp;
    logic [KEY_W-1:0]      victim_key;
  } token_t;

  typedef struct packed {
    wr_op_t                op;
    logic [SLOT_IDX_W-1:0] idx;
    logic                  is_put;
    logic [KEY_W-1:0]      key;
    logic [DATA_W-1:0]     data;
    logic [31:0]           stamp;
  } wr_cmd_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == SAT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

// ===== rtl/lfucl_cell.sv =====
// ----------------------------------------------------------------------------
// lfucl_cell: one cache slot of the search chain
// Holds one entry, folds it into the passing search token and registers the
// token for the next cell; applies broadcast write commands aimed at it.
// ----------------------------------------------------------------------------
module lfucl_cell
  import lfucl_pkg::*;
#(
  parameter int CELL_INDEX = 0
) (
  input  logic    clk,
  input  logic    rst,
  input  token_t  tok_in,
  output token_t  tok_out,
  input  wr_cmd_t cmd
);

  localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(CELL_INDEX);

  logic              valid;
  logic [KEY_W-1:0]  key;
  logic [DATA_W-1:0] data;
  logic [31:0]       count;
  logic [31:0]       stamp;
  token_t            tok_next;

  always_comb begin
    tok_next = tok_in;
    if (tok_in.active && valid) begin
      tok_next.fill = tok_in.fill + FILL_W'(1);
      if (!tok_in.match_found && key == tok_in.key) begin
        tok_next.match_found = 1'b1;
        tok_next.match_idx   = MY_IDX;
        tok_next.match_data  = data;
      end
      // strict compares keep the lowest index on a full tie
      if (!tok_in.victim_found || count < tok_in.victim_count ||
          (count == tok_in.victim_count && stamp < tok_in.victim_stamp)) begin
        tok_next.victim_found = 1'b1;
        tok_next.victim_idx   = MY_IDX;
        tok_next.victim_count = count;
        tok_next.victim_stamp = stamp;
        tok_next.victim_key   = key;
      end
    end else if (tok_in.active && !tok_in.free_found) begin
      tok_next.free_found = 1'b1;
      tok_next.free_idx   = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out.active <= tok_next.active;
    end
    tok_out.key          <= tok_next.key;
    tok_out.fill         <= tok_next.fill;
    tok_out.match_found  <= tok_next.match_found;
    tok_out.match_idx    <= tok_next.match_idx;
    tok_out.match_data   <= tok_next.match_data;
    tok_out.free_found   <= tok_next.free_found;
    tok_out.free_idx     <= tok_next.free_idx;
    tok_out.victim_found <= tok_next.victim_found;
    tok_out.victim_idx   <= tok_next.victim_idx;
    tok_out.victim_count <= tok_next.victim_count;
    tok_out.victim_stamp <= tok_next.victim_stamp;
    tok_out.victim_key   <= tok_next.victim_key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.idx == MY_IDX) begin
      unique case (cmd.op)
        WR_TOUCH: begin
          count <= sat_inc(count);
          stamp <= cmd.stamp;
          if (cmd.is_put) begin
            data <= cmd.data;
          end
        end
        WR_INSTALL: begin
          valid <= 1'b1;
          key   <= cmd.key;
          data  <= cmd.data;
          count <= 32'd0;
          stamp <= cmd.stamp;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/lfu_cache_lookup_and_replace_unit.sv =====
// ----------------------------------------------------------------------------
// Flow: the search token walks the cell chain one slot per cycle, then the
// slot write is issued and the reply registered once the output register
// drains; no new request is accepted until the reply has been loaded.
// Reset: all slots invalid, request epoch zero, capacity 16; no clearing pass.
// ----------------------------------------------------------------------------
// lfu_cache_lookup_and_replace_unit: fully associative LFU cache
// Get/put requests are searched along a chain of slot cells; ties on use
// count go to the oldest stamp, then to the lowest slot.
// ----------------------------------------------------------------------------
module lfu_cache_lookup_and_replace_unit
  import lfucl_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [63:0]      s_tdata,   // [31:0] lookup_key, [63:32] write_data
  input  logic             s_tuser,   // [0] req_type
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [63:0]      m_tdata,   // [31:0] read_data, [63:32] evicted_key
  output logic [1:0]       m_tuser,   // [0] hit, [1] evicted
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

  state_t            state;
  logic [CAP_W-1:0]  capacity;
  logic [31:0]       epoch;
  logic              req_put;
  logic [DATA_W-1:0] req_data;
  wr_cmd_t           cmd;
  wr_cmd_t           cmd_next;
  logic              res_hit;
  logic              res_hit_next;
  logic [DATA_W-1:0] res_rdata;
  logic [DATA_W-1:0] res_rdata_next;
  logic              res_ev;
  logic              res_ev_next;
  logic [KEY_W-1:0]  res_ekey;
  logic [KEY_W-1:0]  res_ekey_next;
  token_t            tok [ENTRIES+1];
  token_t            last;
  logic              in_beat;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_beat   = s_tvalid && s_tready;

  always_comb begin
    tok[0]         = '0;
    tok[0].active  = in_beat;
    tok[0].key     = s_tdata[31:0];
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lfucl_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (tok[i]),
      .tok_out(tok[i+1]),
      .cmd    (cmd)
    );
  end

  assign last = tok[ENTRIES];

  always_comb begin
    cmd_next        = '0;
    cmd_next.op     = WR_NONE;
    cmd_next.is_put = req_put;
    cmd_next.key    = last.key;
    cmd_next.data   = req_data;
    cmd_next.stamp  = epoch;
    res_hit_next    = 1'b0;
    res_rdata_next  = '0;
    res_ev_next     = 1'b0;
    res_ekey_next   = '0;
    if (last.match_found) begin
      res_hit_next   = 1'b1;
      res_rdata_next = req_put ? '0 : last.match_data;
      cmd_next.op    = WR_TOUCH;
      cmd_next.idx   = last.match_idx;
    end else if (req_put && capacity != '0) begin
      if (last.free_found && last.fill < FILL_W'(capacity)) begin
        cmd_next.op  = WR_INSTALL;
        cmd_next.idx = last.free_idx;
      end else if (last.victim_found) begin
        cmd_next.op   = WR_INSTALL;
        cmd_next.idx  = last.victim_idx;
        res_ev_next   = 1'b1;
        res_ekey_next = last.victim_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      capacity <= CAP_RESET;
      epoch    <= 32'd0;
      cmd.op   <= WR_NONE;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        capacity <= cfg_data;
      end
      if (m_tvalid && m_tready && state != ST_HOLD) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            epoch    <= sat_inc(epoch);
            req_put  <= s_tuser;
            req_data <= s_tdata[63:32];
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (last.active) begin
            cmd       <= cmd_next;
            res_hit   <= res_hit_next;
            res_rdata <= res_rdata_next;
            res_ev    <= res_ev_next;
            res_ekey  <= res_ekey_next;
            state     <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          // the slot write lands on the first hold cycle; drop it after
          cmd.op <= WR_NONE;
          // wait for the output register to drain
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {res_ekey, res_rdata};
            m_tuser  <= {res_ev, res_hit};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for lfu_cache_lookup_and_replace_unit
// A cache mirror predicts hit, read data and eviction for every accepted
// request. A short directed run is followed by random get/put traffic over a
// range of capacity settings, with random gaps on the request and reply
// streams.
// ----------------------------------------------------------------------------
module tb_top;
  import lfucl_pkg::*;

  localparam int SLOTS          = ENTRIES_DEFAULT;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int POOL_MAX       = 32;

  typedef enum bit {
    REQ_GET,
    REQ_PUT
  } req_kind_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_data;
    logic        evicted;
    logic [31:0] evicted_key;
  } reply_t;

  class cache_mirror;
    bit               occupied[SLOTS];
    logic [31:0]      tag[SLOTS];
    logic [31:0]      value[SLOTS];
    logic [31:0]      uses[SLOTS];
    logic [31:0]      last_touch[SLOTS];
    logic [31:0]      tick;
    logic [CAP_W-1:0] capacity;
    reply_t           expected[$];
    int               mismatches;
    int               hits;
    int               evictions;

    function new();
      foreach (occupied[i]) occupied[i] = 1'b0;
      tick       = '0;
      capacity   = CAP_RESET;
      mismatches = 0;
      hits       = 0;
      evictions  = 0;
    endfunction

    function logic [31:0] bump(input logic [31:0] v);
      return (v == SAT_MAX) ? v : v + 32'd1;
    endfunction

    function void note_request(input req_kind_t kind, input logic [31:0] k,
                               input logic [31:0] d);
      int     lim;
      int     n_valid;
      int     found;
      int     spare;
      int     victim;
      int     dst;
      reply_t r;
      r       = '0;
      n_valid = 0;
      found   = -1;
      spare   = -1;
      victim  = -1;
      lim     = (capacity < SLOTS) ? int'(capacity) : SLOTS;
      tick    = bump(tick);
      for (int i = 0; i < SLOTS; i++) begin
        if (occupied[i]) begin
          n_valid++;
          if (found < 0 && tag[i] == k) found = i;
          // lowest count wins, then oldest stamp, then lowest slot
          if (victim < 0 || uses[i] < uses[victim] ||
              (uses[i] == uses[victim] && last_touch[i] < last_touch[victim]))
            victim = i;
        end else if (spare < 0) begin
          spare = i;
        end
      end
      if (found >= 0) begin
        r.hit             = 1'b1;
        uses[found]       = bump(uses[found]);
        last_touch[found] = tick;
        if (kind == REQ_PUT) value[found] = d;
        else r.read_data = value[found];
      end else if (kind == REQ_PUT && lim != 0) begin
        if (n_valid < lim && spare >= 0) begin
          dst = spare;
        end else begin
          dst           = victim;
          r.evicted     = 1'b1;
          r.evicted_key = tag[victim];
        end
        occupied[dst]   = 1'b1;
        tag[dst]        = k;
        value[dst]      = d;
        uses[dst]       = '0;
        last_touch[dst] = tick;
      end
      expected = {expected, r};
    endfunction

    function void check_reply(input reply_t got);
      reply_t want;
      if (expected.size() == 0) begin
        $error("reply beat with no request outstanding");
        mismatches++;
        return;
      end
      want = expected.pop_front();
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, got.hit);
        mismatches++;
      end
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %08h, got %08h", want.read_data, got.read_data);
        mismatches++;
      end
      if (got.evicted !== want.evicted) begin
        $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
        mismatches++;
      end
      if (got.evicted_key !== want.evicted_key) begin
        $error("evicted_key: expected %08h, got %08h", want.evicted_key,
               got.evicted_key);
        mismatches++;
      end
      if (want.hit) hits++;
      if (want.evicted) evictions++;
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [63:0]      s_tdata   = '0;   // [31:0] lookup_key, [63:32] write_data
  logic             s_tuser   = 1'b0; // [0] req_type
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [63:0]      m_tdata;          // [31:0] read_data, [63:32] evicted_key
  logic [1:0]       m_tuser;          // [0] hit, [1] evicted
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data  = '0;

  cache_mirror mirror = new();
  logic [31:0] key_pool[POOL_MAX];
  bit          idle_on      = 1'b1;
  bit          hold_request = 1'b0;
  int          requests     = 0;
  int          settings     = 0;
  int          long_holds   = 0;

  lfu_cache_lookup_and_replace_unit #(
    .ENTRIES(SLOTS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_request(input req_kind_t kind, input logic [31:0] key,
                              input logic [31:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {data, key};
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    mirror.note_request(kind, key, data);
    requests++;
  endtask

  // drop valid, wait for every reply, then let the pipeline run dry
  task automatic settle();
    s_tvalid <= 1'b0;
    while (mirror.expected.size() != 0) @(posedge clk);
    repeat (SLOTS + 4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mirror.capacity = cap;
    settings++;
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int count,
                           input int pool_n, input bit idle, input bit long_hold,
                           input bit fresh);
    int          r;
    logic [31:0] key;
    write_capacity(cap);
    idle_on = idle;
    if (fresh) foreach (key_pool[i]) key_pool[i] = $urandom;
    if (long_hold) hold_request = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) settle();
      r = $urandom_range(0, 99);
      if (r < 84) key = key_pool[$urandom_range(0, pool_n - 1)];
      else if (r < 87) key = 32'h0;
      else if (r < 90) key = 32'hFFFF_FFFF;
      else key = $urandom;
      send_request(req_kind_t'($urandom_range(0, 1)), key, $urandom);
    end
  endtask

  // reply side: check each beat, stall at random, hold off long on request
  initial begin : reply_sink
    int stall_left;
    stall_left = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready)
        mirror.check_reply('{hit: m_tuser[0], read_data: m_tdata[31:0],
                             evicted: m_tuser[1], evicted_key: m_tdata[63:32]});
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
        long_holds++;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready   <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (!rst);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset capacity: miss, installs at the key extremes, get and put hits
    send_request(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(REQ_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(REQ_GET, 32'h0000_0000, 32'h1234_5678);
    send_request(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(REQ_PUT, 32'h0000_0000, 32'h1234_5678);
    send_request(REQ_PUT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_request(REQ_GET, 32'h0000_0000, 32'h0000_0000);

    // shrink below the valid count: misses evict the least used entry
    write_capacity(5'd2);
    send_request(REQ_PUT, 32'h0000_0001, 32'h0000_0001);
    send_request(REQ_PUT, 32'h0000_0002, 32'h0000_0002);
    send_request(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(REQ_GET, 32'h0000_0002, 32'h0000_0000);
    send_request(REQ_PUT, 32'h0000_0003, 32'h0000_0003);

    // capacity zero: put misses ignored, put hits still update
    write_capacity(5'd0);
    send_request(REQ_PUT, 32'h0000_0004, 32'hDEAD_BEEF);
    send_request(REQ_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_GET, 32'h0000_0004, 32'h0000_0000);

    // capacity above the slot count
    write_capacity(5'd31);
    send_request(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);

    run_phase(5'd16, 180, 24, 1'b0, 1'b0, 1'b1);
    run_phase(5'd31, 150, 30, 1'b1, 1'b1, 1'b1);
    run_phase(5'd5,  150,  8, 1'b1, 1'b0, 1'b1);
    run_phase(5'd0,   60,  8, 1'b1, 1'b0, 1'b0);
    run_phase(5'd1,  100,  4, 1'b1, 1'b0, 1'b1);
    run_phase(5'd17, 150, 22, 1'b1, 1'b0, 1'b1);
    run_phase(5'd3,  120,  6, 1'b1, 1'b0, 1'b0);
    run_phase(5'd8,  200, 12, 1'b1, 1'b0, 1'b1);
    settle();

    $display("Run covered %0d requests under %0d capacity writes: %0d hits, %0d evictions.",
             requests, settings, mirror.hits, mirror.evictions);
    $display("Reply stream held off for %0d long stretches; %0d field mismatches.",
             long_holds, mirror.mismatches);
    if (mirror.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
